FILE: hw/rtl/ptfp_pkg.sv
// ptfp_pkg: shared types and constants of the palette to framebuffer pixel converter
// holds the input and output item structs, the configuration struct and the code enums
// no dependencies
package ptfp_pkg;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 5;

    typedef enum logic [0:0] {
        OP_WRITE   = 1'b0,
        OP_CONVERT = 1'b1
    } op_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_RED_BITS    = 3'd0,
        REG_RED_SHIFT   = 3'd1,
        REG_GREEN_BITS  = 3'd2,
        REG_GREEN_SHIFT = 3'd3,
        REG_BLUE_BITS   = 3'd4,
        REG_BLUE_SHIFT  = 3'd5,
        REG_BYTES       = 3'd6,
        REG_SCALE       = 3'd7
    } cfg_idx_t;

    typedef struct packed {
        op_t        op;
        logic [7:0] index;
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } in_item_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       last;
    } out_item_t;

    typedef struct packed {
        logic [3:0] red_bits;
        logic [4:0] red_shift;
        logic [3:0] green_bits;
        logic [4:0] green_shift;
        logic [3:0] blue_bits;
        logic [4:0] blue_shift;
        logic [2:0] bytes_per_pixel;
        logic [3:0] scale;
    } cfg_t;

    localparam cfg_t CFG_RESET = '{
        red_bits:        4'd8,
        red_shift:       5'd16,
        green_bits:      4'd8,
        green_shift:     5'd8,
        blue_bits:       4'd8,
        blue_shift:      5'd0,
        bytes_per_pixel: 3'd4,
        scale:           4'd1
    };

endpackage

FILE: hw/rtl/palette_to_framebuffer_pixel.sv
// palette_to_framebuffer_pixel: top level of the palette lookup pixel format converter
// holds the palette memory, the configuration registers and the lookup stage
// depends on ptfp_pkg and ptfp_serializer
//
// A write transfer stores one 24-bit palette entry and yields nothing; a convert transfer
// reads the entry from the single-port palette memory into a register, and the serializer
// then sends the packed word as bytes_per_pixel bytes, low byte first, scale times over,
// flagging the final byte. Writes and convert lookups are taken one per cycle while the
// lookup stage is free; a convert yields bytes_per_pixel * scale bytes (4 at reset), and
// the lookup stage holds the next convert while the current run drains. A convert passes
// the lookup and pixel registers before its first byte. Palette entries must be written
// before they are converted; indexes at or above PALETTE_ENTRIES read as black.
module palette_to_framebuffer_pixel #(
    parameter int PALETTE_ENTRIES = 256,
    parameter int MAX_SCALE       = 8
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [ptfp_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [ptfp_pkg::CFG_DATA_W-1:0]     cfg_data,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  ptfp_pkg::in_item_t                  in_item,
    output logic                                out_valid,
    input  logic                                out_ready,
    output ptfp_pkg::out_item_t                 out_item
);
    import ptfp_pkg::*;

    localparam int AW = $clog2(PALETTE_ENTRIES);

    cfg_t        cfg_reg;
    cfg_t        cfg_next;

    logic [23:0] palette [PALETTE_ENTRIES];
    logic [23:0] rdata_reg;
    logic        look_valid_reg;
    logic        look_valid_next;
    logic        oob_reg;
    logic        in_range;
    logic        in_xfer;
    logic        load_ready;
    logic        advance;
    logic [23:0] entry;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            unique case (cfg_idx_t'(cfg_index))
                REG_RED_BITS:    cfg_next.red_bits        = cfg_data[3:0];
                REG_RED_SHIFT:   cfg_next.red_shift       = cfg_data[4:0];
                REG_GREEN_BITS:  cfg_next.green_bits      = cfg_data[3:0];
                REG_GREEN_SHIFT: cfg_next.green_shift     = cfg_data[4:0];
                REG_BLUE_BITS:   cfg_next.blue_bits       = cfg_data[3:0];
                REG_BLUE_SHIFT:  cfg_next.blue_shift      = cfg_data[4:0];
                REG_BYTES:       cfg_next.bytes_per_pixel = cfg_data[2:0];
                REG_SCALE:       cfg_next.scale           = cfg_data[3:0];
                default:         cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= CFG_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign in_range = ({1'b0, in_item.index} < 9'(PALETTE_ENTRIES));
    assign advance  = look_valid_reg && load_ready;
    assign in_ready = !look_valid_reg || load_ready;
    assign in_xfer  = in_valid && in_ready;

    always_ff @(posedge clk)
    begin
        if (in_xfer && (in_item.op == OP_WRITE) && in_range)
        begin
            palette[in_item.index[AW-1:0]] <= {in_item.red, in_item.green, in_item.blue};
        end
        if (in_xfer && (in_item.op == OP_CONVERT))
        begin
            rdata_reg <= palette[in_item.index[AW-1:0]];
        end
    end

    always_comb
    begin
        look_valid_next = look_valid_reg;
        if (in_xfer && (in_item.op == OP_CONVERT))
        begin
            look_valid_next = 1'b1;
        end
        else if (advance)
        begin
            look_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            look_valid_reg <= 1'b0;
            oob_reg        <= 1'b0;
        end
        else
        begin
            look_valid_reg <= look_valid_next;
            if (in_xfer && (in_item.op == OP_CONVERT))
            begin
                oob_reg <= !in_range;
            end
        end
    end

    assign entry = oob_reg ? 24'd0 : rdata_reg;

    ptfp_serializer #(
        .MAX_SCALE (MAX_SCALE)
    ) u_ser (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .load_valid (look_valid_reg),
        .load_ready (load_ready),
        .entry      (entry),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .out_item   (out_item)
    );

    a_convert_held : assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready && (in_item.op == OP_CONVERT)) |=> look_valid_reg)
        else $error("accepted convert not held in lookup stage");

    a_run_continues : assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_ready && !out_item.last) |=> out_valid)
        else $error("byte run ended without final flag");

    a_idle_after_last : assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_ready && out_item.last && !look_valid_reg) |=> !out_valid)
        else $error("output valid with no pending convert");

    a_stall_holds : assert property (@(posedge clk) disable iff (!rst_n)
        (look_valid_reg && !load_ready) |=> (look_valid_reg && $stable(entry)))
        else $error("lookup stage lost its entry while stalled");

endmodule

FILE: hw/rtl/ptfp_serializer.sv
// ptfp_serializer: packs one palette color into a 32-bit word and sends it byte by byte
// repeats the byte group per the scale setting and flags the final byte
// depends on ptfp_pkg
module ptfp_serializer #(
    parameter int MAX_SCALE = 8
) (
    input  logic              clk,
    input  logic              rst_n,
    input  ptfp_pkg::cfg_t    cfg,
    input  logic              load_valid,
    output logic              load_ready,
    input  logic [23:0]       entry,
    output logic              out_valid,
    input  logic              out_ready,
    output ptfp_pkg::out_item_t out_item
);
    import ptfp_pkg::*;

    localparam int REP_W = $clog2(MAX_SCALE + 1);

    logic [31:0]      pix_reg;
    logic [31:0]      pix_next;
    logic [1:0]       byte_cnt_reg;
    logic [1:0]       byte_cnt_next;
    logic [REP_W-1:0] rep_cnt_reg;
    logic [REP_W-1:0] rep_cnt_next;
    logic             busy_reg;
    logic             busy_next;

    logic [2:0]       nb_eff;
    logic [REP_W-1:0] reps_eff;
    logic [4:0]       scale_ext;
    logic             byte_end;
    logic             run_end;
    logic             xfer;
    logic             load;

    function automatic logic [7:0] keep(input logic [7:0] v, input logic [3:0] bits);
        logic [3:0] b;
        b = (bits > 4'd8) ? 4'd8 : bits;
        return v >> (4'd8 - b);
    endfunction

    function automatic logic [31:0] place(input logic [7:0] v, input logic [4:0] sh);
        return {24'b0, v} << sh;
    endfunction

    always_comb
    begin
        if (cfg.bytes_per_pixel == 3'd0)
        begin
            nb_eff = 3'd1;
        end
        else if (cfg.bytes_per_pixel > 3'd4)
        begin
            nb_eff = 3'd4;
        end
        else
        begin
            nb_eff = cfg.bytes_per_pixel;
        end
        scale_ext = {1'b0, cfg.scale};
        if (scale_ext == 5'd0)
        begin
            reps_eff = REP_W'(1);
        end
        else if (scale_ext > 5'(MAX_SCALE))
        begin
            reps_eff = REP_W'(MAX_SCALE);
        end
        else
        begin
            reps_eff = REP_W'(scale_ext);
        end
    end

    assign byte_end   = ({1'b0, byte_cnt_reg} == (nb_eff - 3'd1));
    assign run_end    = byte_end && (rep_cnt_reg == (reps_eff - REP_W'(1)));
    assign out_valid  = busy_reg;
    assign xfer       = busy_reg && out_ready;
    assign load_ready = !busy_reg || (xfer && run_end);
    assign load       = load_valid && load_ready;

    assign out_item.out_byte = pix_reg[{byte_cnt_reg, 3'b000} +: 8];
    assign out_item.last     = run_end;

    always_comb
    begin
        pix_next      = pix_reg;
        byte_cnt_next = byte_cnt_reg;
        rep_cnt_next  = rep_cnt_reg;
        busy_next     = busy_reg;
        if (load)
        begin
            pix_next = place(keep(entry[23:16], cfg.red_bits), cfg.red_shift)
                     | place(keep(entry[15:8], cfg.green_bits), cfg.green_shift)
                     | place(keep(entry[7:0], cfg.blue_bits), cfg.blue_shift);
            byte_cnt_next = 2'd0;
            rep_cnt_next  = '0;
            busy_next     = 1'b1;
        end
        else if (xfer)
        begin
            if (run_end)
            begin
                busy_next = 1'b0;
            end
            else if (byte_end)
            begin
                byte_cnt_next = 2'd0;
                rep_cnt_next  = rep_cnt_reg + REP_W'(1);
            end
            else
            begin
                byte_cnt_next = byte_cnt_reg + 2'd1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg     <= 1'b0;
            byte_cnt_reg <= 2'd0;
            rep_cnt_reg  <= '0;
        end
        else
        begin
            busy_reg     <= busy_next;
            byte_cnt_reg <= byte_cnt_next;
            rep_cnt_reg  <= rep_cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pix_reg <= pix_next;
    end

endmodule
